@@ hdl/iidl_pkg.sv @@
// Package for the indexed insert/delete list.
// Holds sizes, opcode and status codes, the cell control struct and helper functions.
// No dependencies.
package iidl_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;

    localparam int OP_W       = 3;
    localparam int POS_W      = 7;
    localparam int IN_DATA_W  = 32;
    localparam int RESULT_W   = 32;
    localparam int ST_W       = 2;
    localparam int ENTRY_W    = 7;

    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [OP_W-1:0] OP_READ     = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd2;
    localparam logic [OP_W-1:0] OP_INS_AT   = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE   = 3'd4;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                  ins_en;
        logic                  del_en;
        logic [CMP_W-1:0]      pos;
        logic [DATA_WIDTH-1:0] data;
    } cell_ctrl_t;

    function automatic logic [DATA_WIDTH-1:0] to_cell(input logic [IN_DATA_W-1:0] d);
        logic [DATA_WIDTH-1:0] r;
        for (int i = 0; i < DATA_WIDTH; i++)
        begin
            r[i] = d[(i < IN_DATA_W) ? i : IN_DATA_W - 1];
        end
        return r;
    endfunction

    function automatic logic [RESULT_W-1:0] to_result(input logic [DATA_WIDTH-1:0] v);
        logic [RESULT_W-1:0] r;
        for (int i = 0; i < RESULT_W; i++)
        begin
            r[i] = v[(i < DATA_WIDTH) ? i : DATA_WIDTH - 1];
        end
        return r;
    endfunction

endpackage

@@ hdl/iidl_if.sv @@
// Handshake interfaces for the command and response channels of the list.
// Depends on iidl_pkg for field widths.
interface iidl_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [iidl_pkg::OP_W-1:0]            opcode;
    logic [iidl_pkg::POS_W-1:0]           position;
    logic signed [iidl_pkg::IN_DATA_W-1:0] data_in;

    modport source (output valid, opcode, position, data_in, input ready);
    modport sink   (input valid, opcode, position, data_in, output ready);
endinterface

interface iidl_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [iidl_pkg::RESULT_W-1:0] read_value;
    logic [iidl_pkg::ST_W-1:0]            status;
    logic [iidl_pkg::ENTRY_W-1:0]         entry_count;

    modport source (output valid, read_value, status, entry_count, input ready);
    modport sink   (input valid, read_value, status, entry_count, output ready);
endinterface

@@ hdl/indexed_insert_delete_list.sv @@
// Indexed insert/delete list: a chain of CAPACITY cells that shift in parallel.
// The response is registered and valid in the cycle after the command transfer.
// One command is taken every cycle while responses are taken, since the whole chain
// shifts in the same cycle and the result register frees as its response is taken.
// Reset clears the entry count and the response valid; cell contents stay undefined
// until written. Depends on iidl_pkg, iidl_if and iidl_cell.
module indexed_insert_delete_list
(
    input  logic            clk,
    input  logic            rst_n,
    iidl_in_if.sink         cmd,
    iidl_out_if.source      rsp
);
    import iidl_pkg::*;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  out_valid_reg;
    logic [RESULT_W-1:0]   value_reg;
    logic [RESULT_W-1:0]   value_next;
    logic [ST_W-1:0]       status_reg;
    logic [ST_W-1:0]       status_next;

    logic                  cmd_fire;
    logic [CMP_W-1:0]      pos_x;
    logic [CMP_W-1:0]      cnt_x;
    logic [CMP_W-1:0]      ins_pos;
    logic                  is_insert;
    logic [DATA_WIDTH-1:0] read_word;
    cell_ctrl_t            ctrl;

    logic [DATA_WIDTH-1:0] cell_val [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_tap [CAPACITY];

    assign cmd.ready = !out_valid_reg || rsp.ready;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign pos_x     = CMP_W'(cmd.position);
    assign cnt_x     = CMP_W'(count_reg);

    always_comb
    begin
        read_word = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            read_word = read_word | cell_tap[i];
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        value_next  = '0;
        status_next = ST_RANGE;
        is_insert   = 1'b0;
        ins_pos     = pos_x;
        ctrl.ins_en = 1'b0;
        ctrl.del_en = 1'b0;
        ctrl.data   = to_cell(cmd.data_in);

        case (cmd.opcode)
            OP_READ:
            begin
                if (pos_x < cnt_x)
                begin
                    value_next  = to_result(read_word);
                    status_next = ST_DONE;
                end
                else
                begin
                    value_next  = '1;
                    status_next = ST_RANGE;
                end
            end
            OP_INS_HEAD:
            begin
                is_insert = 1'b1;
                ins_pos   = '0;
            end
            OP_INS_TAIL:
            begin
                is_insert = 1'b1;
                ins_pos   = cnt_x;
            end
            OP_INS_AT:
            begin
                is_insert = 1'b1;
                ins_pos   = pos_x;
            end
            OP_DELETE:
            begin
                if (pos_x < cnt_x)
                begin
                    ctrl.del_en = cmd_fire;
                    count_next  = count_reg - CNT_W'(1);
                    status_next = ST_DONE;
                end
            end
            default:
            begin
                status_next = ST_RANGE;
            end
        endcase

        if (is_insert)
        begin
            if (ins_pos > cnt_x)
                status_next = ST_RANGE;
            else if (count_reg == CNT_W'(CAPACITY))
                status_next = ST_FULL;
            else
            begin
                ctrl.ins_en = cmd_fire;
                count_next  = count_reg + CNT_W'(1);
                status_next = ST_DONE;
            end
        end

        ctrl.pos = ctrl.del_en ? pos_x : ins_pos;
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] prev_w;
            logic [DATA_WIDTH-1:0] next_w;

            if (g == 0)
            begin : g_first
                assign prev_w = ctrl.data;
            end
            else
            begin : g_prev
                assign prev_w = cell_val[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign next_w = cell_val[g];
            end
            else
            begin : g_next
                assign next_w = cell_val[g+1];
            end

            iidl_cell u_cell
            (
                .clk        (clk),
                .ctrl       (ctrl),
                .cell_index (CMP_W'(g)),
                .prev_value (prev_w),
                .next_value (next_w),
                .value      (cell_val[g]),
                .tap        (cell_tap[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_fire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_value  = value_reg;
    assign rsp.status      = status_reg;
    assign rsp.entry_count = ENTRY_W'(count_reg);

endmodule

@@ hdl/iidl_cell.sv @@
// One storage cell of the list chain; depends on iidl_pkg.
// Takes the left neighbour's value or the new data on an insert, the right one's on delete.
module iidl_cell
(
    input  logic                            clk,
    input  iidl_pkg::cell_ctrl_t            ctrl,
    input  logic [iidl_pkg::CMP_W-1:0]      cell_index,
    input  logic [iidl_pkg::DATA_WIDTH-1:0] prev_value,
    input  logic [iidl_pkg::DATA_WIDTH-1:0] next_value,
    output logic [iidl_pkg::DATA_WIDTH-1:0] value,
    output logic [iidl_pkg::DATA_WIDTH-1:0] tap
);
    import iidl_pkg::*;

    logic [DATA_WIDTH-1:0] value_reg;
    logic [DATA_WIDTH-1:0] value_next;
    logic                  at_pos;
    logic                  above_pos;

    assign at_pos    = (cell_index == ctrl.pos);
    assign above_pos = (cell_index > ctrl.pos);

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins_en)
        begin
            if (above_pos)
                value_next = prev_value;
            else if (at_pos)
                value_next = ctrl.data;
        end
        else if (ctrl.del_en)
        begin
            if (above_pos || at_pos)
                value_next = next_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign tap   = at_pos ? value_reg : '0;

endmodule

@@ hdl/iidl_checker.sv @@
// Port-level checks for the indexed insert/delete list, bound to the top level.
// Depends on iidl_pkg and indexed_insert_delete_list.
module iidl_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              cmd_valid,
    input logic                              cmd_ready,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input logic [iidl_pkg::RESULT_W-1:0]     rsp_read_value,
    input logic [iidl_pkg::ST_W-1:0]         rsp_status,
    input logic [iidl_pkg::ENTRY_W-1:0]      rsp_entry_count
);
    import iidl_pkg::*;

    a_rsp_held: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("Response withdrawn before its transfer.");

    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> rsp_valid)
        else $error("No response one cycle after a command transfer.");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_entry_count <= ENTRY_W'(CAPACITY))
        else $error("Entry count exceeds capacity.");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_FULL |->
            rsp_entry_count == ENTRY_W'(CAPACITY) && rsp_read_value == '0)
        else $error("Full status without a full list or with a read value.");

endmodule

bind indexed_insert_delete_list iidl_checker u_iidl_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_read_value  (rsp.read_value),
    .rsp_status      (rsp.status),
    .rsp_entry_count (rsp.entry_count)
);

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking bench for indexed_insert_delete_list: queued commands, a clocked driver,
// a clocked monitor and an in-bench list predictor. Depends on iidl_pkg, iidl_if and the RTL.
module testbench;
    import iidl_pkg::*;

    typedef struct {
        logic [OP_W-1:0]             opcode;
        logic [POS_W-1:0]            position;
        logic signed [IN_DATA_W-1:0] data;
        int                          gap;
    } list_command_t;

    typedef struct {
        logic signed [RESULT_W-1:0] read_value;
        logic [ST_W-1:0]            status;
        logic [ENTRY_W-1:0]         entry_count;
    } list_response_t;

    logic clk;
    logic rst_n;

    iidl_in_if  cmd_if ();
    iidl_out_if rsp_if ();

    indexed_insert_delete_list uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    list_command_t  pending_commands[$];
    list_response_t expected_responses[$];
    list_command_t  next_command;
    list_command_t  taken_command;
    list_response_t expected_now;

    logic [DATA_WIDTH-1:0] list_cells [CAPACITY];
    int                    list_count = 0;

    logic [OP_W-1:0] insert_ops [3] = '{OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT};

    int tx_wait         = 0;
    bit quiet_sender    = 1'b0;
    int fill_level      = 0;
    int rx_wait         = 0;
    int rx_wait_n       = 0;
    bit rx_quiet        = 1'b0;
    int rx_segment_left = 0;
    int error_count     = 0;
    int responses_seen  = 0;
    logic sink_hold     = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic [ST_W-1:0] place_value(input int at, input logic [DATA_WIDTH-1:0] v);
        if (at > list_count)
        begin
            return ST_RANGE;
        end
        if (list_count >= CAPACITY)
        begin
            return ST_FULL;
        end
        for (int i = list_count; i > at; i--)
        begin
            list_cells[i] = list_cells[i - 1];
        end
        list_cells[at] = v;
        list_count++;
        return ST_DONE;
    endfunction

    function automatic list_response_t apply_list_command(input list_command_t c);
        list_response_t r;
        int             p;
        p            = int'(c.position);
        r.read_value = '0;
        r.status     = ST_RANGE;
        case (c.opcode)
            OP_READ:
            begin
                if (p < list_count)
                begin
                    r.read_value = RESULT_W'($signed(list_cells[p]));
                    r.status     = ST_DONE;
                end
                else
                begin
                    r.read_value = '1;
                end
            end
            OP_INS_HEAD: r.status = place_value(0, c.data[DATA_WIDTH-1:0]);
            OP_INS_TAIL: r.status = place_value(list_count, c.data[DATA_WIDTH-1:0]);
            OP_INS_AT:   r.status = place_value(p, c.data[DATA_WIDTH-1:0]);
            OP_DELETE:
            begin
                if (p < list_count)
                begin
                    for (int i = p; i + 1 < list_count; i++)
                    begin
                        list_cells[i] = list_cells[i + 1];
                    end
                    list_count--;
                    r.status = ST_DONE;
                end
            end
            default: r.status = ST_RANGE;
        endcase
        r.entry_count = ENTRY_W'(list_count);
        return r;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 10)
        begin
            $display("%s", msg);
        end
    endtask

    // The occupancy estimate only steers positions towards the live range.
    task automatic queue_command(input logic [OP_W-1:0] op, input int pos,
                                 input logic [IN_DATA_W-1:0] data);
        list_command_t c;
        c.opcode   = op;
        c.position = pos[POS_W-1:0];
        c.data     = data;
        c.gap      = quiet_sender ? 0 : $urandom_range(0, 12);
        pending_commands.push_back(c);
        if ((op == OP_INS_HEAD || op == OP_INS_TAIL || (op == OP_INS_AT && pos <= fill_level))
            && fill_level < CAPACITY)
        begin
            fill_level++;
        end
        else if (op == OP_DELETE && pos < fill_level)
        begin
            fill_level--;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_if.valid    <= 1'b0;
            cmd_if.opcode   <= OP_READ;
            cmd_if.position <= '0;
            cmd_if.data_in  <= '0;
            tx_wait         <= 0;
        end
        else
        begin
            if (cmd_if.valid && cmd_if.ready)
            begin
                taken_command.opcode   = cmd_if.opcode;
                taken_command.position = cmd_if.position;
                taken_command.data     = cmd_if.data_in;
                taken_command.gap      = 0;
                expected_responses.push_back(apply_list_command(taken_command));
            end
            if (!cmd_if.valid || cmd_if.ready)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait      <= tx_wait - 1;
                    cmd_if.valid <= 1'b0;
                end
                else if (pending_commands.size() > 0)
                begin
                    next_command     = pending_commands.pop_front();
                    cmd_if.valid    <= 1'b1;
                    cmd_if.opcode   <= next_command.opcode;
                    cmd_if.position <= next_command.position;
                    cmd_if.data_in  <= next_command.data;
                    tx_wait         <= next_command.gap;
                end
                else
                begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            rx_wait      <= 0;
        end
        else
        begin
            rx_wait_n = rx_wait;
            if (rsp_if.valid && rsp_if.ready)
            begin
                responses_seen++;
                if (expected_responses.size() == 0)
                begin
                    flag_error($sformatf("unexpected response: value %0d status %0d count %0d",
                               rsp_if.read_value, rsp_if.status, rsp_if.entry_count));
                end
                else
                begin
                    expected_now = expected_responses.pop_front();
                    if (rsp_if.read_value !== expected_now.read_value
                        || rsp_if.status !== expected_now.status
                        || rsp_if.entry_count !== expected_now.entry_count)
                    begin
                        flag_error($sformatf({"response mismatch: expected value %0d status %0d ",
                                   "count %0d, got value %0d status %0d count %0d"},
                                   expected_now.read_value, expected_now.status,
                                   expected_now.entry_count, rsp_if.read_value,
                                   rsp_if.status, rsp_if.entry_count));
                    end
                end
                if (rx_segment_left == 0)
                begin
                    rx_quiet        = ($urandom_range(0, 2) == 0);
                    rx_segment_left = $urandom_range(20, 80);
                end
                rx_segment_left--;
                rx_wait_n = rx_quiet ? 0 : $urandom_range(0, 12);
            end
            if (sink_hold)
            begin
                rsp_if.ready <= 1'b0;
                rx_wait      <= rx_wait_n;
            end
            else if (rx_wait_n > 0)
            begin
                rsp_if.ready <= 1'b0;
                rx_wait      <= rx_wait_n - 1;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                rx_wait      <= 0;
            end
        end
    end

    // The sink stops taking responses for a long stretch so that the list stalls its input.
    initial
    begin
        while (responses_seen < 400)
        begin
            @(posedge clk);
        end
        sink_hold <= 1'b1;
        repeat (300) @(posedge clk);
        sink_hold <= 1'b0;
    end

    initial
    begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int round_kind;
        int round_len;
        int issued;
        int roll;
        int pos;
        logic [OP_W-1:0]      op;
        logic [IN_DATA_W-1:0] data;

        queue_command(OP_READ, 0, 32'h0000_0000);
        queue_command(OP_DELETE, 0, 32'hFFFF_FFFF);
        queue_command(OP_INS_AT, 1, 32'h0000_0005);
        queue_command(OP_INS_AT, 0, 32'h7FFF_FFFF);
        queue_command(OP_INS_TAIL, 0, 32'h8000_0000);
        queue_command(OP_INS_HEAD, 0, 32'hFFFF_FFFF);
        queue_command(OP_INS_AT, 3, 32'h0000_0000);
        queue_command(OP_INS_AT, 2, 32'h5555_AAAA);
        for (int i = 0; i < 5; i++)
        begin
            queue_command(OP_READ, i, 32'hAAAA_5555);
        end
        queue_command(OP_READ, 5, 32'h0000_0000);
        queue_command(OP_READ, 127, 32'h0000_0000);
        queue_command(OP_DELETE, 127, 32'h0000_0000);
        queue_command(3'd5, 0, 32'h1234_5678);
        queue_command(3'd6, 127, 32'hFFFF_FFFF);
        queue_command(3'd7, 64, 32'h8000_0000);
        queue_command(OP_DELETE, 2, 32'h0000_0000);
        queue_command(OP_DELETE, 0, 32'h0000_0000);
        queue_command(OP_DELETE, 2, 32'h0000_0000);
        queue_command(OP_READ, 1, 32'h0000_0000);
        queue_command(OP_READ, 0, 32'h0000_0000);
        queue_command(OP_INS_AT, 64, 32'h0F0F_0F0F);

        // The opening round grows the list until inserts are refused for lack of room.
        issued = 0;
        round_kind = 0;
        round_len = 200;
        while (issued < 1500)
        begin
            quiet_sender = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < round_len; n++)
            begin
                roll = $urandom_range(0, 99);
                case (round_kind)
                    0:       op = (roll < 70) ? insert_ops[$urandom_range(0, 2)] :
                                  (roll < 85) ? OP_READ : OP_DELETE;
                    1:       op = (roll < 65) ? OP_DELETE :
                                  (roll < 85) ? OP_READ : insert_ops[$urandom_range(0, 2)];
                    2:       op = (roll < 30) ? insert_ops[$urandom_range(0, 2)] :
                                  (roll < 60) ? OP_DELETE : OP_READ;
                    default: op = OP_W'($urandom_range(0, 7));
                endcase
                if (round_kind == 3 || $urandom_range(0, 99) >= 88)
                begin
                    pos = $urandom_range(0, 127);
                end
                else if (op == OP_INS_AT)
                begin
                    pos = $urandom_range(0, fill_level);
                end
                else
                begin
                    pos = $urandom_range(0, (fill_level > 0) ? fill_level - 1 : 0);
                end
                case ($urandom_range(0, 15))
                    0:       data = 32'h7FFF_FFFF;
                    1:       data = 32'h8000_0000;
                    2:       data = 32'h0000_0000;
                    3:       data = 32'hFFFF_FFFF;
                    default: data = $urandom();
                endcase
                queue_command(op, pos, data);
                issued++;
            end
            round_kind = $urandom_range(0, 3);
            round_len  = $urandom_range(40, 120);
        end

        while (pending_commands.size() != 0 || cmd_if.valid || expected_responses.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (expected_responses.size() != 0)
        begin
            flag_error($sformatf("%0d responses never arrived", expected_responses.size()));
        end
        if (error_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/iidl_pkg.sv
hdl/iidl_if.sv
hdl/iidl_cell.sv
hdl/indexed_insert_delete_list.sv
hdl/iidl_checker.sv
bench/testbench.sv
